// ===== rtl/longest_prefix_route_lookup_unit_defines.svh =====
// Assertion helpers shared by the verification code of the route lookup unit.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LPRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("route lookup check failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define LPRL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("route lookup sequence check failed");

`endif

// ===== rtl/lprl_pkg.sv =====
package lprl_pkg;

  // Fixed field widths of the input and result words.
  localparam int unsigned AddrW = 32;
  localparam int unsigned PortW = 2;
  localparam int unsigned SlotW = 4;

  // Command codes carried in the input word.
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // Input word: either a route write or an address lookup.
  typedef struct packed {
    cmd_e             command;
    logic [SlotW-1:0] entry_slot;
    logic [AddrW-1:0] entry_prefix;
    logic [AddrW-1:0] entry_mask;
    logic [AddrW-1:0] entry_gateway;
    logic [PortW-1:0] entry_port;
    logic             entry_valid;
    logic [AddrW-1:0] query_address;
  } in_word_t;

  // Result word, one per input word.
  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] next_hop;
    logic [PortW-1:0] out_port;
    logic [AddrW-1:0] matched_mask;
  } out_word_t;

  // One route as stored in the table memory.
  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gateway;
    logic [PortW-1:0] port;
  } route_entry_t;

  // Control states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

endpackage

// ===== rtl/lprl_stream_if.sv =====
// Input channel: valid/ready handshake carrying one input word.
interface lprl_in_if;
  import lprl_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel: valid/ready handshake carrying one result word.
interface lprl_out_if;
  import lprl_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lprl_ram.sv =====
module lprl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/longest_prefix_route_lookup_unit.sv =====
// A write word passes from the idle state to the done state; a lookup word passes
// through the scan state first, which reads all min(TABLE_DEPTH,16) table slots,
// one per cycle, through the single read port of the route memory. The result word
// is registered when the done state sees a free result channel; no new word is taken before then.
// Reset clears every valid mark, the control state and the result valid flag;
// the route memory and the result payload are not cleared.
module longest_prefix_route_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned PORT_COUNT  = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lprl_in_if.sink    in_i,
  lprl_out_if.source out_o
);
  import lprl_pkg::*;

  // Only slots reachable through the slot field are ever populated.
  localparam int unsigned SlotCount = (TABLE_DEPTH < (1 << SlotW)) ? TABLE_DEPTH
                                                                  : (1 << SlotW);
  localparam int unsigned IdxW = $clog2(SlotCount);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  state_e state_q, state_d;

  logic             valid_q [SlotCount];
  logic [CntW-1:0]  rd_cnt_q, rd_cnt_d;
  logic             pend_q;
  logic [IdxW-1:0]  pend_idx_q;
  logic [AddrW-1:0] query_q;
  logic             found_q, found_d;
  logic [AddrW-1:0] best_mask_q, best_mask_d;
  logic [AddrW-1:0] best_gw_q, best_gw_d;
  logic [PortW-1:0] best_port_q, best_port_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  logic         in_acc;
  logic         slot_ok;
  logic         port_ok;
  logic         ram_we;
  logic         ram_re;
  route_entry_t wr_entry;
  route_entry_t rd_entry;
  logic         slot_match;
  logic         out_free;

  // The block takes a word only when no other word is in flight.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Writes outside the table or naming a missing port are dropped.
  assign slot_ok = ({1'b0, in_i.data.entry_slot} < (SlotW + 1)'(SlotCount));
  assign port_ok = (5'(in_i.data.entry_port) < 5'(PORT_COUNT));
  assign ram_we  = in_acc && (in_i.data.command == CMD_WRITE) && slot_ok && port_ok;

  assign wr_entry = '{
    prefix:  in_i.data.entry_prefix,
    mask:    in_i.data.entry_mask,
    gateway: in_i.data.entry_gateway,
    port:    in_i.data.entry_port
  };

  // The scan issues one read per cycle until every slot has been requested.
  assign ram_re = (state_q == ST_SCAN) && (rd_cnt_q < CntW'(SlotCount));

  lprl_ram #(
    .Width ($bits(route_entry_t)),
    .Depth (SlotCount)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.data.entry_slot[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // A returned slot replaces the best route when it is valid, matches and is longer.
  assign slot_match = pend_q && valid_q[pend_idx_q] &&
                      ((query_q & rd_entry.mask) == rd_entry.prefix) &&
                      (!found_q || (rd_entry.mask > best_mask_q));

  assign out_free = !out_valid_q || out_o.ready;

  // Next-state and datapath selection.
  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    found_d     = found_q;
    best_mask_d = best_mask_q;
    best_gw_d   = best_gw_q;
    best_port_d = best_port_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (slot_match) begin
      found_d     = 1'b1;
      best_mask_d = rd_entry.mask;
      best_gw_d   = rd_entry.gateway;
      best_port_d = rd_entry.port;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          found_d  = 1'b0;
          rd_cnt_d = '0;
          state_d  = (in_i.data.command == CMD_LOOKUP) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (ram_re) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        if (pend_q && (pend_idx_q == LastIdx)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.hit          = found_q;
          out_d.next_hop     = found_q ? best_gw_q : '0;
          out_d.out_port     = found_q ? best_port_q : '0;
          out_d.matched_mask = found_q ? best_mask_q : '0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      pend_q      <= ram_re;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        valid_q[in_i.data.entry_slot[IdxW-1:0]] <= in_i.data.entry_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_idx_q  <= rd_cnt_q[IdxW-1:0];
    best_mask_q <= best_mask_d;
    best_gw_q   <= best_gw_d;
    best_port_q <= best_port_d;
    out_q       <= out_d;
    if (in_acc) begin
      query_q <= in_i.data.query_address;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== rtl/lprl_checker.sv =====
`include "longest_prefix_route_lookup_unit_defines.svh"

module lprl_checker #(
  parameter int unsigned PortCount = 4
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input lprl_pkg::out_word_t      out_data_i
);
  import lprl_pkg::*;

  logic in_acc;
  logic out_stall;
  logic out_miss;
  logic out_hit;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_miss  = out_valid_i && !out_data_i.hit;
  assign out_hit   = out_valid_i && out_data_i.hit;

  // A stalled result word stays put.
  `LPRL_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(out_data_i))

  // Only one word is in flight: the block is busy right after taking one.
  `LPRL_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_i)

  // A miss or a write reports all-zero route fields.
  `LPRL_ASSERT(a_miss_zero, !out_miss || ((out_data_i.next_hop == '0) &&
    (out_data_i.out_port == '0) && (out_data_i.matched_mask == '0)))

  // A hit never names a port the block does not have.
  `LPRL_ASSERT(a_hit_port, !out_hit || (5'(out_data_i.out_port) < 5'(PortCount)))

endmodule

bind longest_prefix_route_lookup_unit lprl_checker #(
  .PortCount (PORT_COUNT)
) u_lprl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
